FILE: rtl/core/hcht_pkg.sv
// Package for the hit-count high-water tracker: shared widths, constants and types.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package hcht_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SlotW   = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned FloorW  = 8;
  localparam int unsigned GrowthW = 10;
  localparam int unsigned UsedW   = 17;
  localparam int unsigned CreditW = 32;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgIdxW = 2;

  // Percentage arithmetic: mark * (100 + growth) + 100 fits in ProdW bits.
  localparam int unsigned PctScale = 100;
  localparam int unsigned BaseW    = GrowthW + 1;
  localparam int unsigned ProdW    = 19;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFloor  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGrowth = CfgIdxW'(1);

  // Configuration reset values.
  localparam logic [FloorW-1:0]  FloorReset  = FloorW'(4);
  localparam logic [GrowthW-1:0] GrowthReset = GrowthW'(25);

  // Pass mode codes.
  localparam logic FuncCheck  = 1'b0;
  localparam logic FuncAbsorb = 1'b1;

  // Depth of the result queue.
  localparam int unsigned ResQDepth = 3;
  localparam int unsigned ResQPtrW  = 2;

  typedef struct packed {
    logic               improved;
    logic [CountW-1:0]  pass_max_count;
    logic [UsedW-1:0]   slots_used;
    logic [CreditW-1:0] credit_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcht_store.sv
// High-water mark memory with one write and one registered read port, plus the
// clearing sweep that zeroes every entry after reset. Uses hcht_pkg.
`default_nettype none

module hcht_store
  import hcht_pkg::*;
#(
  parameter int unsigned MAP_SLOTS = 65536,
  parameter int unsigned AW        = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [CountW-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [CountW-1:0] wr_data_i,
  output logic                   busy_o
);

  logic [CountW-1:0] mem [MAP_SLOTS];
  logic [CountW-1:0] rd_data_q;
  logic              busy_q, busy_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic              we;
  logic [AW-1:0]     wa;
  logic [CountW-1:0] wd;

  // The sweep walks every entry once, one per cycle, then stops for good.
  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      if (clr_addr_q == AW'(MAP_SLOTS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port while it runs.
  assign we = busy_q | wr_en_i;
  assign wa = busy_q ? clr_addr_q : wr_addr_i;
  assign wd = busy_q ? '0 : wr_data_i;

  // Read returns the value held before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

FILE: rtl/core/hcht_update.sv
// Update stage: decides whether a slot's count raises its mark, writes it back,
// keeps the counters and pass values and forms the result. Uses hcht_pkg.
`default_nettype none

module hcht_update
  import hcht_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request entering the stage (memory read issued at the same edge).
  input  wire logic               in_valid_i,
  input  wire logic               in_func_i,
  input  wire logic               in_range_i,
  input  wire logic [AW-1:0]      in_addr_i,
  input  wire logic [CountW-1:0]  in_count_i,
  input  wire logic               in_last_i,
  // Registered read data from the store.
  input  wire logic [CountW-1:0]  rd_data_i,
  // Configuration.
  input  wire logic [FloorW-1:0]  floor_i,
  input  wire logic [GrowthW-1:0] growth_i,
  // Write back to the store.
  output logic                    wr_en_o,
  output logic      [AW-1:0]      wr_addr_o,
  output logic      [CountW-1:0]  wr_data_o,
  // Result towards the queue.
  output logic                    res_push_o,
  output result_t                 res_o
);

  logic              s1_valid_q;
  logic              s1_func_q;
  logic              s1_range_q;
  logic [AW-1:0]     s1_addr_q;
  logic [CountW-1:0] s1_count_q;
  logic              s1_last_q;

  logic              fwd_hit_q, fwd_hit_d;
  logic [CountW-1:0] fwd_data_q;

  logic [UsedW-1:0]   used_q, used_d;
  logic [CreditW-1:0] credit_q, credit_d;
  logic               imp_q, imp_d;
  logic [CountW-1:0]  max_q, max_d;

  logic [CountW-1:0] mark;
  logic [BaseW-1:0]  growth_base;
  logic [ProdW-1:0]  need;
  logic [ProdW-1:0]  have;
  logic              above;
  logic              take_chk;
  logic              take;
  logic              imp_upd;
  logic [CountW-1:0] max_upd;

  // Pipeline register of the update stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_func_q  <= in_func_i;
      s1_range_q <= in_range_i;
      s1_addr_q  <= in_addr_i;
      s1_count_q <= in_count_i;
      s1_last_q  <= in_last_i;
    end
  end

  // A write at the edge where the next request reads the same slot is
  // forwarded, since the memory returns the old value then.
  assign fwd_hit_d = wr_en_o && in_valid_i && in_range_i && (in_addr_i == s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data_o;
  end

  assign mark = fwd_hit_q ? fwd_data_q : rd_data_i;

  // Growth test: count * 100 >= mark * (100 + growth) + 100.
  assign growth_base = BaseW'(PctScale) + BaseW'(growth_i);
  assign need        = ProdW'(mark) * ProdW'(growth_base) + ProdW'(PctScale);
  assign have        = ProdW'(s1_count_q) * ProdW'(PctScale);

  assign above    = s1_count_q > mark;
  assign take_chk = s1_valid_q && (s1_func_q == FuncCheck) && s1_range_q && above &&
                    (s1_count_q >= floor_i) && ((mark == '0) || (have >= need));
  assign take     = take_chk ||
                    (s1_valid_q && (s1_func_q == FuncAbsorb) && s1_range_q && above);

  assign wr_en_o   = take;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = s1_count_q;

  // Counters and pass values, including the effect of the current request.
  always_comb begin
    used_d   = used_q;
    credit_d = credit_q;
    if (take && (mark == '0) && (used_q != '1)) begin
      used_d = used_q + UsedW'(1);
    end
    if (take_chk && (credit_q != '1)) begin
      credit_d = credit_q + CreditW'(1);
    end
    imp_upd = imp_q | take_chk;
    max_upd = max_q;
    if (s1_valid_q && (s1_func_q == FuncAbsorb) && (s1_count_q > max_q)) begin
      max_upd = s1_count_q;
    end
    imp_d = imp_upd;
    max_d = max_upd;
    if (s1_valid_q && s1_last_q) begin
      imp_d = 1'b0;
      max_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      credit_q <= '0;
      imp_q    <= 1'b0;
      max_q    <= '0;
    end else begin
      used_q   <= used_d;
      credit_q <= credit_d;
      imp_q    <= imp_d;
      max_q    <= max_d;
    end
  end

  // The last request of a pass yields a result for the reported mode.
  assign res_push_o           = s1_valid_q && s1_last_q;
  assign res_o.improved       = (s1_func_q == FuncCheck) ? imp_upd : 1'b0;
  assign res_o.pass_max_count = (s1_func_q == FuncAbsorb) ? max_upd : '0;
  assign res_o.slots_used     = used_d;
  assign res_o.credit_count   = credit_d;

endmodule

`default_nettype wire

FILE: rtl/core/hcht_resq.sv
// Small result queue that decouples the update stage from the output channel.
// Uses hcht_pkg for the result type and the queue depth.
`default_nettype none

module hcht_resq
  import hcht_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire result_t             data_i,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output result_t                  data_o,
  output logic      [ResQPtrW-1:0] count_o
);

  result_t               q_mem [ResQDepth];
  logic [ResQPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ResQPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ResQPtrW-1:0]   count_q, count_d;
  logic                  do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Pointer and fill-level update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ResQPtrW'(ResQDepth - 1)) ? '0 : wr_ptr_q + ResQPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ResQPtrW'(ResQDepth - 1)) ? '0 : rd_ptr_q + ResQPtrW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + ResQPtrW'(1);
      2'b01:   count_d = count_q - ResQPtrW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = q_mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/hit_count_high_water_tracker.sv
// Top level of the hit-count high-water tracker: request and result channels,
// configuration registers and admission. Uses hcht_pkg, hcht_store, hcht_update, hcht_resq.
//
// Usage
//   Requests (func, slot_index, hit_count, last_slot) enter on in_valid_i /
//   in_ready_o; one request per map slot. The request with last_slot set closes
//   the pass and produces one result on out_valid_o / out_ready_i; other
//   requests produce none.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
//   clock edge; index 0 is the floor count, index 1 the growth percentage.
//   Throughput is one request per cycle while in_ready_o is high: the mark
//   memory is read at the edge that accepts a request and written back at the
//   next edge, with the written value forwarded to a directly following
//   request for the same slot. A result passes the update stage register and
//   the result queue register before it is visible on the output.
//   After reset the mark memory is cleared one entry per cycle; in_ready_o
//   stays low until every entry is cleared, while configuration writes are
//   taken as usual.
//   If the receiver stalls, up to three results wait in a queue; requests keep
//   flowing until that queue, counting results still in flight, is full.
`default_nettype none

module hit_count_high_water_tracker
  import hcht_pkg::*;
#(
  parameter int unsigned MAP_SLOTS = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port.
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  // Request channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               func_i,
  input  wire logic [SlotW-1:0]   slot_index_i,
  input  wire logic [CountW-1:0]  hit_count_i,
  input  wire logic               last_slot_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    improved_o,
  output logic [CountW-1:0]       pass_max_count_o,
  output logic [UsedW-1:0]        slots_used_o,
  output logic [CreditW-1:0]      credit_count_o
);

  localparam int unsigned AW = $clog2(MAP_SLOTS);
  localparam int unsigned CW = ((AW > SlotW) ? AW : SlotW) + 1;

  logic [FloorW-1:0]  floor_q;
  logic [GrowthW-1:0] growth_q;

  logic              accept;
  logic [CW-1:0]     slot_wide;
  logic              in_range;
  logic [AW-1:0]     slot_addr;

  logic [CountW-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CountW-1:0] wr_data;
  logic              store_busy;

  logic                res_push;
  result_t             res_in;
  result_t             res_out;
  logic [ResQPtrW-1:0] q_count;
  logic [ResQPtrW:0]   q_commit;

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= FloorReset;
      growth_q <= GrowthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFloor:  floor_q  <= cfg_wdata_i[FloorW-1:0];
        RegGrowth: growth_q <= cfg_wdata_i[GrowthW-1:0];
        default:   ;
      endcase
    end
  end

  // Slot decode: out-of-range slots never touch the memory.
  assign slot_wide = CW'(slot_index_i);
  assign in_range  = slot_wide < CW'(MAP_SLOTS);
  assign slot_addr = slot_wide[AW-1:0];

  // Admission: queued results plus one possibly in flight must leave room.
  assign q_commit   = (ResQPtrW + 1)'(q_count) + (ResQPtrW + 1)'(res_push);
  assign in_ready_o = !store_busy && (q_commit < (ResQPtrW + 1)'(ResQDepth));
  assign accept     = in_valid_i && in_ready_o;

  hcht_store #(
    .MAP_SLOTS (MAP_SLOTS),
    .AW        (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (slot_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (store_busy)
  );

  hcht_update #(
    .AW (AW)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_func_i  (func_i),
    .in_range_i (in_range),
    .in_addr_i  (slot_addr),
    .in_count_i (hit_count_i),
    .in_last_i  (last_slot_i),
    .rd_data_i  (rd_data),
    .floor_i    (floor_q),
    .growth_i   (growth_q),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  hcht_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (res_out),
    .count_o (q_count)
  );

  assign improved_o       = res_out.improved;
  assign pass_max_count_o = res_out.pass_max_count;
  assign slots_used_o     = res_out.slots_used;
  assign credit_count_o   = res_out.credit_count;

endmodule

`default_nettype wire

FILE: sim/hcht_checker.sv
// Checker for the hit-count high-water tracker. It follows configuration writes, predicts a
// summary for every request that closes a pass and compares it with the result channel.
// Depends on hcht_pkg for widths, register indexes, mode codes and result_t.
`default_nettype none

module hcht_checker
  import hcht_pkg::*;
#(
  parameter int unsigned MapSlots = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               func_i,
  input  wire logic [SlotW-1:0]   slot_index_i,
  input  wire logic [CountW-1:0]  hit_count_i,
  input  wire logic               last_slot_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic               improved_i,
  input  wire logic [CountW-1:0]  pass_max_count_i,
  input  wire logic [UsedW-1:0]   slots_used_i,
  input  wire logic [CreditW-1:0] credit_count_i,
  output logic [31:0]             pending_o,
  output logic [31:0]             fail_count_o
);

  localparam logic [UsedW-1:0]   UsedLimit   = '1;
  localparam logic [CreditW-1:0] CreditLimit = '1;

  // Predicted state of the block.
  logic [CountW-1:0]  marks [MapSlots];
  logic [UsedW-1:0]   used_slots;
  logic [CreditW-1:0] credits;
  logic               pass_raised;
  logic [CountW-1:0]  pass_peak;
  logic [FloorW-1:0]  floor_level;
  logic [GrowthW-1:0] growth_pct;

  // Summaries of closed passes still waiting on the result channel.
  result_t            summary_q [$];
  result_t            want;
  int unsigned        outstanding = 0;
  int unsigned        mismatches  = 0;

  assign pending_o    = outstanding;
  assign fail_count_o = mismatches;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [CreditW-1:0] seen,
                                 input logic [CreditW-1:0] wanted);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, seen, wanted);
    mismatches++;
  endtask

  // Applies one request to the predicted marks and counters, and queues the pass
  // summary when the request closes the pass.
  task automatic track_hit_count(input logic func, input logic [SlotW-1:0] slot,
                                 input logic [CountW-1:0] cnt, input logic last);
    logic [CountW-1:0] mark;
    logic              take;
    int unsigned       need;
    result_t           summary;
    if (func == FuncAbsorb && cnt > pass_peak) begin
      pass_peak = cnt;
    end
    if (32'(slot) < MapSlots) begin
      mark = marks[slot];
      take = cnt > mark;
      // A check request must also reach the floor and beat an existing mark by the step.
      if (func == FuncCheck) begin
        need = mark * (PctScale + growth_pct) + PctScale;
        take = take && cnt >= floor_level && (mark == '0 || cnt * PctScale >= need);
      end
      if (take) begin
        if (mark == '0 && used_slots != UsedLimit) begin
          used_slots++;
        end
        marks[slot] = cnt;
        if (func == FuncCheck) begin
          if (credits != CreditLimit) begin
            credits++;
          end
          pass_raised = 1'b1;
        end
      end
    end
    if (last) begin
      summary.improved       = (func == FuncCheck) ? pass_raised : 1'b0;
      summary.pass_max_count = (func == FuncAbsorb) ? pass_peak : '0;
      summary.slots_used     = used_slots;
      summary.credit_count   = credits;
      summary_q.push_back(summary);
      pass_raised = 1'b0;
      pass_peak   = '0;
    end
  endtask

  // Everything is sampled at the rising edge; requests are applied before results are taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < MapSlots; i++) begin
        marks[i] = '0;
      end
      used_slots  = '0;
      credits     = '0;
      pass_raised = 1'b0;
      pass_peak   = '0;
      floor_level = FloorReset;
      growth_pct  = GrowthReset;
      summary_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFloor:  floor_level = cfg_wdata_i[FloorW-1:0];
          RegGrowth: growth_pct  = cfg_wdata_i[GrowthW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        track_hit_count(func_i, slot_index_i, hit_count_i, last_slot_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (summary_q.size() == 0) begin
          report_mismatch("result count (no closed pass waiting)", 1, 0);
        end else begin
          want = summary_q.pop_front();
          if (improved_i !== want.improved) begin
            report_mismatch("improved", improved_i, want.improved);
          end
          if (pass_max_count_i !== want.pass_max_count) begin
            report_mismatch("pass_max_count", pass_max_count_i, want.pass_max_count);
          end
          if (slots_used_i !== want.slots_used) begin
            report_mismatch("slots_used", slots_used_i, want.slots_used);
          end
          if (credit_count_i !== want.credit_count) begin
            report_mismatch("credit_count", credit_count_i, want.credit_count);
          end
        end
      end
    end
    outstanding = summary_q.size();
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench top for the hit-count high-water tracker: clock, reset, configuration writes,
// directed and random requests, and the verdict. Depends on hcht_pkg, hcht_checker and the block.
`default_nettype none

module tb_top;
  import hcht_pkg::*;

  localparam int unsigned MapSlots   = 65536;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned PhaseItems = 270;
  // Indexes beyond the two registers; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareHi = CfgIdxW'(3);

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               func_i;
  logic [SlotW-1:0]   slot_index_i;
  logic [CountW-1:0]  hit_count_i;
  logic               last_slot_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               improved_o;
  logic [CountW-1:0]  pass_max_count_o;
  logic [UsedW-1:0]   slots_used_o;
  logic [CreditW-1:0] credit_count_o;
  logic [31:0]        pending_results;
  logic [31:0]        mismatch_total;
  logic               steady = 1'b0;

  hit_count_high_water_tracker #(
    .MAP_SLOTS(MapSlots)
  ) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .func_i, .slot_index_i, .hit_count_i, .last_slot_i,
    .out_valid_o, .out_ready_i, .improved_o, .pass_max_count_o, .slots_used_o,
    .credit_count_o
  );

  hcht_checker #(
    .MapSlots(MapSlots)
  ) mark_monitor (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .slot_index_i, .hit_count_i,
    .last_slot_i, .out_valid_i(out_valid_o), .out_ready_i,
    .improved_i(improved_o), .pass_max_count_i(pass_max_count_o),
    .slots_used_i(slots_used_o), .credit_count_i(credit_count_o),
    .pending_o(pending_results), .fail_count_o(mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver stalls at random, except during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Hard limit on the run, well beyond the clearing pass and the slowest stimulus.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge once cfg_we_i is low again.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with valid still high so that the next request can follow without a gap.
  task automatic send_request(input logic func, input logic [SlotW-1:0] slot,
                              input logic [CountW-1:0] cnt, input logic last);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    slot_index_i <= slot;
    hit_count_i  <= cnt;
    last_slot_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops requests and waits until every closed pass has reported, then lets the
  // write-back of the last request finish.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // One random phase: a register setting, then passes of random length. Most passes keep
  // to one mode and two small regions of slots so that marks build up; the rest is noise.
  task automatic stream_passes(input logic [CfgW-1:0] floor_val,
                               input logic [CfgW-1:0] growth_val, input int unsigned items);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       style;
    logic              func;
    logic [SlotW-1:0]  slot;
    logic [SlotW-1:0]  prev;
    logic [CountW-1:0] cnt;
    settle_block();
    write_reg(RegFloor, floor_val);
    write_reg(RegGrowth, growth_val);
    sent = 0;
    prev = '0;
    while (sent < items) begin
      len   = $urandom_range(12, 1);
      style = $urandom_range(99);
      for (int k = 0; k < len; k++) begin
        if (style < 75) begin
          func = (style < 40) ? FuncCheck : FuncAbsorb;
          if ($urandom_range(4) == 0) begin
            slot = prev;
          end else begin
            slot = ($urandom_range(1) != 0 ? 16'hFFC0 : 16'h0000) + 16'($urandom_range(63));
          end
          if (func == FuncAbsorb && $urandom_range(1) != 0) begin
            cnt = CountW'($urandom_range(31));
          end else begin
            cnt = CountW'($urandom_range(255));
          end
        end else begin
          func = 1'($urandom_range(1));
          slot = SlotW'($urandom);
          cnt  = CountW'($urandom);
        end
        send_request(func, slot, cnt, k == len - 1);
        prev = slot;
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegFloor;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = FuncCheck;
    slot_index_i = '0;
    hit_count_i  = '0;
    last_slot_i  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values written back explicitly; the spare indexes must be ignored.
    write_reg(RegFloor, CfgW'(FloorReset));
    write_reg(RegGrowth, CfgW'(GrowthReset));
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, CfgW'(7));

    // One slot: below the floor, at the floor, short of the growth step, exactly on it,
    // equal to the mark, then a check pass that raises nothing.
    send_request(FuncCheck, 16'h0000, 8'd3, 1'b0);
    send_request(FuncCheck, 16'h0000, 8'd4, 1'b0);
    send_request(FuncCheck, 16'h0000, 8'd5, 1'b1);
    send_request(FuncCheck, 16'h0000, 8'd6, 1'b0);
    send_request(FuncCheck, 16'h0000, 8'd6, 1'b1);
    send_request(FuncCheck, 16'h0000, 8'd0, 1'b1);
    // Absorb passes: top slot with the full count, and a pass whose maximum is zero.
    send_request(FuncAbsorb, 16'hFFFF, 8'd255, 1'b0);
    send_request(FuncAbsorb, 16'h0001, 8'd1, 1'b0);
    send_request(FuncAbsorb, 16'h0001, 8'd0, 1'b1);
    send_request(FuncAbsorb, 16'h0000, 8'd0, 1'b1);
    // Mixed passes: the mode of the closing request decides which field is reported.
    send_request(FuncAbsorb, 16'h0002, 8'd200, 1'b0);
    send_request(FuncCheck, 16'h0003, 8'd100, 1'b1);
    send_request(FuncCheck, 16'h0004, 8'd50, 1'b0);
    send_request(FuncAbsorb, 16'h0005, 8'd77, 1'b1);
    send_request(FuncAbsorb, 16'hFFFF, 8'd255, 1'b1);
    // Two requests for one slot in a row, then alternating bit patterns.
    send_request(FuncCheck, 16'h8000, 8'd128, 1'b0);
    send_request(FuncCheck, 16'h8000, 8'd255, 1'b1);
    send_request(FuncAbsorb, 16'hAAAA, 8'h55, 1'b0);
    send_request(FuncAbsorb, 16'h5555, 8'hAA, 1'b1);

    // A floor of zero behaves as one; the upper data bits of a floor write are dropped.
    settle_block();
    write_reg(RegFloor, 10'h300);
    write_reg(RegGrowth, '0);
    send_request(FuncCheck, 16'h0010, 8'd1, 1'b0);
    send_request(FuncCheck, 16'h0010, 8'd2, 1'b1);

    // Floor of one with a thousand percent growth: just short of the step, then on it.
    settle_block();
    write_reg(RegFloor, CfgW'(1));
    write_reg(RegGrowth, CfgW'(1000));
    send_request(FuncCheck, 16'h0011, 8'd1, 1'b0);
    send_request(FuncCheck, 16'h0011, 8'd11, 1'b0);
    send_request(FuncCheck, 16'h0011, 8'd12, 1'b1);

    // Largest floor and largest growth field.
    settle_block();
    write_reg(RegFloor, '1);
    write_reg(RegGrowth, '1);
    send_request(FuncCheck, 16'h0012, 8'd254, 1'b0);
    send_request(FuncCheck, 16'h0012, 8'd255, 1'b1);

    // Random phases over several settings; the second one runs without any stalls.
    stream_passes(CfgW'(2), CfgW'(0), PhaseItems);
    steady = 1'b1;
    stream_passes(CfgW'(4), CfgW'(25), PhaseItems);
    steady = 1'b0;
    stream_passes(CfgW'(255), CfgW'(1000), PhaseItems);
    stream_passes(CfgW'(1), CfgW'(1023), PhaseItems);
    stream_passes(CfgW'(8), CfgW'(50), PhaseItems);
    stream_passes(CfgW'(0), CfgW'(10), PhaseItems);

    settle_block();
    if (mismatch_total == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
